// File: rtl/core/buddy_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// buddy_block_allocator_defines
// assertion macros for the buddy allocator, empty bodies when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// checked on every edge outside reset
`define BBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define BBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(label, prop, msg)
`define BBA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// word types, op codes and status codes of the buddy allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

  localparam int SIZE_W = 11;
  localparam int BADDR_W = 10;
  localparam int GADDR_W = 10;
  localparam int STATUS_W = 2;
  localparam int CFG_W = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd2;

  typedef struct packed {
    logic op;
    logic [SIZE_W-1:0] request_size;
    logic [BADDR_W-1:0] block_address;
  } req_word_t;

  typedef struct packed {
    logic [GADDR_W-1:0] granted_address;
    logic [STATUS_W-1:0] status;
  } rsp_word_t;

endpackage

// File: rtl/core/bba_link_mem.sv
// ----------------------------------------------------------------------------
// bba_link_mem
// next-link store, one entry per block offset, one write and one read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_link_mem #(
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [ADDR_BITS:0]   wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [ADDR_BITS:0]   rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [ADDR_BITS:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator: allocate rounds the size up, scans the lists upward, pops a block and splits it down
// free: rounding as above, then per merge level a walk of that level's list for the buddy,
// up to WALK_LIMIT nodes per level, then a push of the merged block and the result word
// one word in flight; the next request is taken once the result sits in the output register
// reset: the S_INIT state seeds the root link, then ready with the pool at order 10 (clamped)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "buddy_block_allocator_defines.svh"

module buddy_block_allocator #(
  parameter int ADDR_BITS = 10,
  parameter int LEVEL_COUNT = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  bba_pkg::req_word_t               req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output bba_pkg::rsp_word_t               rsp,
  input  logic                             cfg_we,
  input  logic [bba_pkg::CFG_W-1:0]        cfg_data
);

  import bba_pkg::*;

  localparam int PTR_W = ADDR_BITS + 1;
  localparam int LVL_W = $clog2(LEVEL_COUNT);
  localparam int MAX_ORDER = (ADDR_BITS < LEVEL_COUNT - 1) ? ADDR_BITS : LEVEL_COUNT - 1;
  localparam int RESET_ORDER = (MAX_ORDER < 10) ? MAX_ORDER : 10;
  localparam int CMP_W = ((ADDR_BITS > SIZE_W - 1) ? ADDR_BITS : SIZE_W - 1) + 2;
  localparam int STEP_W = ADDR_BITS + 1;
  localparam int WALK_LIMIT = (1 << ADDR_BITS) + 1;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(1) << ADDR_BITS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SIZE, S_ASCAN, S_APOP, S_ASPLIT,
    S_FCHK, S_FWALK, S_FWAIT, S_FPUSH, S_DONE
  } state_t;

  state_t               state;
  logic                 op_r;
  logic [SIZE_W-1:0]    size_r;
  logic [ADDR_BITS-1:0] addr_a;
  logic [ADDR_BITS-1:0] blk;
  logic [LVL_W-1:0]     tgt;
  logic [LVL_W-1:0]     cur_lvl;
  logic [LVL_W-1:0]     po;
  logic [PTR_W-1:0]     prev;
  logic [PTR_W-1:0]     cur;
  logic [STEP_W-1:0]    steps;
  logic [PTR_W-1:0]     heads [LEVEL_COUNT];
  rsp_word_t            res;

  logic [PTR_W-1:0]     head_rd;
  logic [ADDR_BITS-1:0] lvl_bit;
  logic [ADDR_BITS-1:0] buddy;
  logic [ADDR_BITS-1:0] pool_mask;
  logic [ADDR_BITS-1:0] low_mask;
  logic                 bad_size;
  logic                 walk_end;
  logic                 hit;
  logic [LVL_W-1:0]     cfg_order;
  logic                 load_rsp;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [PTR_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic [PTR_W-1:0]     mem_rdata;

  bba_link_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_ready = (state == S_IDLE) && !cfg_we;
  assign head_rd = heads[cur_lvl];
  assign lvl_bit = ADDR_BITS'(1) << cur_lvl;
  assign buddy = addr_a ^ lvl_bit;
  assign pool_mask = (ADDR_BITS'(1) << po) - ADDR_BITS'(1);
  assign low_mask = (ADDR_BITS'(1) << tgt) - ADDR_BITS'(1);
  assign bad_size = (req.request_size == '0) ||
                    (CMP_W'(req.request_size) > (CMP_W'(1) << po));
  assign walk_end = cur[ADDR_BITS] || (steps == STEP_W'(WALK_LIMIT));
  assign hit = (cur[ADDR_BITS-1:0] == buddy);
  assign cfg_order = (int'(cfg_data) > MAX_ORDER) ? LVL_W'(MAX_ORDER) : LVL_W'(cfg_data);
  assign load_rsp = (state == S_DONE) && !cfg_we && (!rsp_valid || rsp_ready);

  // link store port steering
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = NIL;
    mem_re = 1'b0;
    mem_raddr = head_rd[ADDR_BITS-1:0];
    if (cfg_we) begin
      mem_we = 1'b1;
    end else begin
      case (state)
        S_INIT: begin
          mem_we = 1'b1;
        end
        S_ASCAN: begin
          mem_re = !head_rd[ADDR_BITS];
        end
        S_ASPLIT: begin
          mem_we = 1'b1;
          mem_waddr = blk | lvl_bit;
          mem_wdata = head_rd;
        end
        S_FWALK: begin
          mem_re = !walk_end;
          mem_raddr = cur[ADDR_BITS-1:0];
        end
        S_FWAIT: begin
          // unlink from the middle of the list
          mem_we = hit && !prev[ADDR_BITS];
          mem_waddr = prev[ADDR_BITS-1:0];
          mem_wdata = mem_rdata;
        end
        S_FPUSH: begin
          mem_we = 1'b1;
          mem_waddr = addr_a;
          mem_wdata = head_rd;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      rsp_valid <= 1'b0;
      po <= LVL_W'(RESET_ORDER);
      for (int k = 0; k < LEVEL_COUNT; k++) begin
        heads[k] <= NIL;
      end
      heads[RESET_ORDER] <= '0;
    end else begin
      if (load_rsp) begin
        rsp <= res;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        po <= cfg_order;
        for (int k = 0; k < LEVEL_COUNT; k++) begin
          heads[k] <= NIL;
        end
        heads[cfg_order] <= '0;
      end else begin
        case (state)
          S_INIT: begin
            state <= S_IDLE;
          end
          S_IDLE: begin
            if (req_valid) begin
              op_r <= req.op;
              size_r <= req.request_size;
              addr_a <= ADDR_BITS'(req.block_address);
              tgt <= '0;
              if (bad_size) begin
                res.granted_address <= '0;
                res.status <= ST_BAD_SIZE;
                state <= S_DONE;
              end else begin
                state <= S_SIZE;
              end
            end
          end
          S_SIZE: begin
            // round the size up to a power of two, one level a cycle while cfg_we is low
            if ((CMP_W'(1) << tgt) < CMP_W'(size_r)) begin
              tgt <= tgt + LVL_W'(1);
            end else begin
              cur_lvl <= tgt;
              res.granted_address <= '0;
              res.status <= ST_DONE;
              if (op_r == OP_ALLOC) begin
                state <= S_ASCAN;
              end else begin
                addr_a <= addr_a & pool_mask & ~low_mask;
                state <= S_FCHK;
              end
            end
          end
          S_ASCAN: begin
            if (!head_rd[ADDR_BITS]) begin
              blk <= head_rd[ADDR_BITS-1:0];
              state <= S_APOP;
            end else if (cur_lvl == po) begin
              res.status <= ST_NO_BLOCK;
              state <= S_DONE;
            end else begin
              cur_lvl <= cur_lvl + LVL_W'(1);
            end
          end
          S_APOP: begin
            heads[cur_lvl] <= mem_rdata;
            res.granted_address <= GADDR_W'(blk);
            if (cur_lvl != tgt) begin
              cur_lvl <= cur_lvl - LVL_W'(1);
              state <= S_ASPLIT;
            end else begin
              state <= S_DONE;
            end
          end
          S_ASPLIT: begin
            // upper half goes on this level's list
            heads[cur_lvl] <= {1'b0, blk | lvl_bit};
            if (cur_lvl == tgt) begin
              state <= S_DONE;
            end else begin
              cur_lvl <= cur_lvl - LVL_W'(1);
            end
          end
          S_FCHK: begin
            if (cur_lvl == po) begin
              state <= S_FPUSH;
            end else begin
              prev <= NIL;
              cur <= head_rd;
              steps <= '0;
              state <= S_FWALK;
            end
          end
          S_FWALK: begin
            if (walk_end) begin
              state <= S_FPUSH;
            end else begin
              state <= S_FWAIT;
            end
          end
          S_FWAIT: begin
            if (hit) begin
              if (prev[ADDR_BITS]) begin
                heads[cur_lvl] <= mem_rdata;
              end
              addr_a <= addr_a & ~lvl_bit;
              cur_lvl <= cur_lvl + LVL_W'(1);
              state <= S_FCHK;
            end else begin
              prev <= cur;
              cur <= mem_rdata;
              steps <= steps + STEP_W'(1);
              state <= S_FWALK;
            end
          end
          S_FPUSH: begin
            heads[cur_lvl] <= {1'b0, addr_a};
            state <= S_DONE;
          end
          S_DONE: begin
            if (load_rsp) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  `BBA_ASSERT(a_one_word_in_flight, (req_valid && req_ready) |=> !req_ready, "second word taken while busy")
  `BBA_ASSERT(a_walk_below_pool, (state == S_FWALK || state == S_FWAIT) |-> (cur_lvl < po), "buddy walk at or above pool order")
  `BBA_ASSERT(a_grant_only_on_done, (rsp_valid && rsp.status != ST_DONE) |-> (rsp.granted_address == '0), "address given with a failure status")
  `BBA_ASSERT_ALWAYS(a_no_word_after_reset, rst |=> !rsp_valid, "result valid right after reset")

endmodule
